// ===== src/plint_pkg.sv =====
`default_nettype none

package plint_pkg;

    // field widths
    localparam int TIME_W    = 16;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 4;
    localparam int CFG_W     = 5;
    localparam int STATUS_W  = 2;

    // stream word layout: point_index, point_time, point_value, query_time, then pad
    localparam int S_TDATA_W = 72;
    localparam int IDX_LSB   = 0;
    localparam int PT_LSB    = IDX_LSB + IDX_W;
    localparam int PV_LSB    = PT_LSB + TIME_W;
    localparam int QT_LSB    = PV_LSB + VAL_W;

    // divider: magnitude of a 33x17 product, divided by a time span
    localparam int DIV_W     = 48;
    localparam int DIV_CW    = 6;

    // range status codes
    localparam logic [STATUS_W-1:0] RANGE_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] RANGE_BELOW  = 2'd1;
    localparam logic [STATUS_W-1:0] RANGE_BEYOND = 2'd2;

    // input word kinds carried in tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // one breakpoint as stored
    typedef struct packed {
        logic        [TIME_W-1:0] ptime;
        logic signed [VAL_W-1:0]  pvalue;
    } t_point;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUM,
        ST_OUT
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== src/plint_mem.sv =====
`default_nettype none

module plint_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                   i_clk,
    input  wire                   i_we,
    input  wire  [AW-1:0]         i_waddr,
    input  plint_pkg::t_point     i_wdata,
    input  wire  [AW-1:0]         i_raddr,
    output plint_pkg::t_point     o_rdata
);

    plint_pkg::t_point r_mem [DEPTH];
    plint_pkg::t_point r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/plint_div.sv =====
`default_nettype none

module plint_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire  [plint_pkg::DIV_W-1:0]      i_dividend,
    input  wire  [plint_pkg::TIME_W-1:0]     i_divisor,
    output plint_pkg::t_div_stat             o_stat,
    output logic [plint_pkg::DIV_W-1:0]      o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [plint_pkg::DIV_CW-1:0]   r_cnt;
    logic [plint_pkg::DIV_W-1:0]    r_acc;
    logic [plint_pkg::TIME_W-1:0]   r_rem;
    logic [plint_pkg::TIME_W-1:0]   r_dvs;

    logic [plint_pkg::TIME_W:0]     w_shift;
    logic [plint_pkg::TIME_W+1:0]   w_trial;
    logic                           w_borrow;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        w_shift  = {r_rem, r_acc[plint_pkg::DIV_W-1]};
        w_trial  = {1'b0, w_shift} - {2'b00, r_dvs};
        w_borrow = w_trial[plint_pkg::TIME_W+1];
    end

    // step counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == plint_pkg::DIV_CW'(plint_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= {r_acc[plint_pkg::DIV_W-2:0], ~w_borrow};
            r_rem <= w_borrow ? w_shift[plint_pkg::TIME_W-1:0]
                              : w_trial[plint_pkg::TIME_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_acc;

endmodule

`default_nettype wire

// ===== src/piecewise_linear_interpolator_top.sv =====
// Piecewise linear interpolator over up to MAX_POINTS breakpoints (unsigned
// 16-bit time, signed Q16.16 value) held in a single-port-read memory. A load
// word (tuser 0) writes one slot and gives no result; slots at or above
// MAX_POINTS are ignored. A query word (tuser 1) walks the table one entry
// per cycle from slot 0 until the first time at or above the query time,
// then either returns that value (exact match, or clamped with status 1 below
// the first time, status 2 beyond the last used point) or interpolates with one
// 33x17 multiply and a bit-serial divider that dominates the time a query
// takes. The input side is not ready while a query is in flight, nor while
// the result waits for the output register to drain; a finished result
// sits in an output register so that loads and the next query may be taken
// before it is drained. The table has no reset: a query must only touch
// slots that were loaded.
`default_nettype none

module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration: points_in_use
    input  wire                                  i_cfg_wen,
    input  wire  [plint_pkg::CFG_W-1:0]          i_cfg_wdata,
    // input stream
    input  wire                                  i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // point_index, point_time, point_value, query_time, zero pad
    input  wire  [plint_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // mode
    input  wire                                  i_s_axis_tuser,
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  wire                                  i_m_axis_tready,
    // value
    output logic [plint_pkg::VAL_W-1:0]          o_m_axis_tdata,
    // range_status
    output logic [plint_pkg::STATUS_W-1:0]       o_m_axis_tuser
);

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    plint_pkg::t_state                  r_state, n_state;
    logic [plint_pkg::CFG_W-1:0]        r_cfg;
    logic [plint_pkg::TIME_W-1:0]       r_t;
    logic [AW-1:0]                      r_k;
    logic [AW-1:0]                      r_last;
    plint_pkg::t_point                  r_prev;
    logic signed [plint_pkg::VAL_W:0]   r_diff;
    logic [plint_pkg::TIME_W-1:0]       r_dtn;
    logic [plint_pkg::TIME_W-1:0]       r_dt;
    logic signed [49:0]                 r_prod;
    logic                               r_neg;
    logic [plint_pkg::VAL_W-1:0]        r_res;
    logic [plint_pkg::STATUS_W-1:0]     r_status;
    logic                               r_out_valid;
    logic [plint_pkg::VAL_W-1:0]        r_out_data;
    logic [plint_pkg::STATUS_W-1:0]     r_out_status;

    logic                               w_accept;
    logic                               w_query;
    logic [plint_pkg::IDX_W-1:0]        w_idx;
    plint_pkg::t_point                  w_wpoint;
    logic                               w_we;
    logic [AW-1:0]                      w_raddr;
    plint_pkg::t_point                  w_rd;
    logic [AW-1:0]                      w_last;
    logic                               w_div_start;
    logic [plint_pkg::DIV_W-1:0]        w_mag;
    logic signed [49:0]                 w_neg_prod;
    plint_pkg::t_div_stat               w_div;
    logic [plint_pkg::DIV_W-1:0]        w_quo;
    logic signed [plint_pkg::VAL_W:0]   w_q;
    logic signed [plint_pkg::VAL_W:0]   w_sum;
    logic                               w_out_free;

    // input word fields
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_query         = (i_s_axis_tuser == plint_pkg::MODE_QUERY);
    assign w_idx           = i_s_axis_tdata[plint_pkg::PT_LSB-1:plint_pkg::IDX_LSB];
    assign w_wpoint.ptime  = i_s_axis_tdata[plint_pkg::PV_LSB-1:plint_pkg::PT_LSB];
    assign w_wpoint.pvalue = i_s_axis_tdata[plint_pkg::QT_LSB-1:plint_pkg::PV_LSB];
    assign w_we            = w_accept && !w_query && (32'(w_idx) < 32'(MAX_POINTS));
    assign o_s_axis_tready = (r_state == plint_pkg::ST_IDLE);

    // last searched slot from points_in_use, clamped to [2, MAX_POINTS]
    always_comb begin
        if (r_cfg < plint_pkg::CFG_W'(2)) begin
            w_last = AW'(1);
        end else if (32'(r_cfg) > 32'(MAX_POINTS)) begin
            w_last = AW'(MAX_POINTS - 1);
        end else begin
            w_last = AW'(r_cfg - 1'b1);
        end
    end

    // read address: slot 0 when idle, next slot while searching
    assign w_raddr = (r_state == plint_pkg::ST_SEARCH) ? r_k + 1'b1 : '0;

    plint_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_idx)),
        .i_wdata (w_wpoint),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // magnitude of the product for the divider
    assign w_neg_prod  = -r_prod;
    assign w_mag       = r_neg ? w_neg_prod[plint_pkg::DIV_W-1:0]
                               : r_prod[plint_pkg::DIV_W-1:0];
    assign w_div_start = (r_state == plint_pkg::ST_DIV_GO);

    plint_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_dt),
        .o_stat     (w_div),
        .o_quotient (w_quo)
    );

    // signed quotient added to the previous value
    assign w_q   = r_neg ? -$signed({1'b0, w_quo[plint_pkg::VAL_W-1:0]})
                         : $signed({1'b0, w_quo[plint_pkg::VAL_W-1:0]});
    assign w_sum = $signed({r_prev.pvalue[plint_pkg::VAL_W-1], r_prev.pvalue}) + w_q;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plint_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plint_pkg::ST_IDLE: begin
                if (w_accept && w_query) n_state = plint_pkg::ST_SEARCH;
            end
            plint_pkg::ST_SEARCH: begin
                if (r_t <= w_rd.ptime) begin
                    if (r_t == w_rd.ptime || r_k == '0) begin
                        n_state = plint_pkg::ST_OUT;
                    end else begin
                        n_state = plint_pkg::ST_MUL;
                    end
                end else if (r_k == r_last) begin
                    n_state = plint_pkg::ST_OUT;
                end
            end
            plint_pkg::ST_MUL:      n_state = plint_pkg::ST_DIV_GO;
            plint_pkg::ST_DIV_GO:   n_state = plint_pkg::ST_DIV_WAIT;
            plint_pkg::ST_DIV_WAIT: begin
                if (w_div.done) n_state = plint_pkg::ST_SUM;
            end
            plint_pkg::ST_SUM:      n_state = plint_pkg::ST_OUT;
            plint_pkg::ST_OUT: begin
                if (w_out_free) n_state = plint_pkg::ST_IDLE;
            end
            default:                n_state = plint_pkg::ST_IDLE;
        endcase
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= plint_pkg::CFG_W'(2);
        end else if (i_cfg_wen) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            plint_pkg::ST_IDLE: begin
                r_t    <= i_s_axis_tdata[plint_pkg::QT_LSB+plint_pkg::TIME_W-1:plint_pkg::QT_LSB];
                r_k    <= '0;
                r_last <= w_last;
            end
            plint_pkg::ST_SEARCH: begin
                if (r_t <= w_rd.ptime) begin
                    r_res    <= w_rd.pvalue;
                    r_status <= (r_t == w_rd.ptime) ? plint_pkg::RANGE_INSIDE
                              : (r_k == '0)         ? plint_pkg::RANGE_BELOW
                                                    : plint_pkg::RANGE_INSIDE;
                    r_diff   <= $signed({w_rd.pvalue[plint_pkg::VAL_W-1], w_rd.pvalue})
                              - $signed({r_prev.pvalue[plint_pkg::VAL_W-1], r_prev.pvalue});
                    r_dtn    <= r_t - r_prev.ptime;
                    r_dt     <= w_rd.ptime - r_prev.ptime;
                end else if (r_k == r_last) begin
                    r_res    <= w_rd.pvalue;
                    r_status <= plint_pkg::RANGE_BEYOND;
                end else begin
                    r_prev <= w_rd;
                    r_k    <= r_k + 1'b1;
                end
            end
            plint_pkg::ST_MUL: begin
                // time offset is positive, so the product takes the sign of the difference
                r_prod <= r_diff * $signed({1'b0, r_dtn});
                r_neg  <= r_diff[plint_pkg::VAL_W];
            end
            plint_pkg::ST_SUM: begin
                r_res <= w_sum[plint_pkg::VAL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == plint_pkg::ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == plint_pkg::ST_OUT && w_out_free) begin
            r_out_data   <= r_res;
            r_out_status <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    // the search never runs past the last used slot
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plint_pkg::ST_SEARCH) |-> (r_k <= r_last))
        else $error("search index beyond last used slot");

    // an accepted query always starts the search
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_query) |=> (r_state == plint_pkg::ST_SEARCH))
        else $error("query accepted without search");

    // divider is idle whenever new words are taken
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_div.busy)
        else $error("divider busy while ready");

    // waiting on the divider means it is running or just finished
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plint_pkg::ST_DIV_WAIT) |-> (w_div.busy || w_div.done))
        else $error("waiting on an idle divider");

    // no status code three ever leaves
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser != 2'd3))
        else $error("invalid range status");

endmodule

`default_nettype wire
